// ----- rtl/core/sfd_pkg.sv -----
// sfd_pkg: shared types and constants for the SYN flood detector.
// No dependencies; imported by the parser, engine, top level and testbench.
package sfd_pkg;

  // Frame layout (byte offsets into the Ethernet frame)
  localparam int unsigned TCP_HDR_POS = 34;
  localparam int unsigned FRAME_MIN   = 48;
  localparam int unsigned POS_W       = 6;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
  localparam int unsigned FLAG_SYN_BIT  = 1;   // 0x02
  localparam int unsigned FLAG_ACK_BIT  = 4;   // 0x10

  localparam int unsigned CMD_FIFO_DEPTH = 4;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned LPORT_W = 17;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // listen_port value that watches all ports
  localparam logic [LPORT_W-1:0] LPORT_ALL = '1;

  typedef enum logic {
    OP_BYTE       = 1'b0,
    OP_WINDOW_END = 1'b1
  } op_e;

  typedef enum logic {
    RPT_ATTACKER = 1'b0,
    RPT_SUMMARY  = 1'b1
  } rpt_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LISTEN_IP   = 2'd0,
    CFG_LISTEN_PORT = 2'd1,
    CFG_THRESHOLD   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [IP_W-1:0]    listen_ip;
    logic [LPORT_W-1:0] listen_port;
    logic [THR_W-1:0]   threshold;
  } cfg_t;

  // Command handed from the parser to the counting engine
  typedef struct packed {
    op_e               kind;
    logic              ipv4_tcp;
    logic              syn;
    logic              ack;
    logic [IP_W-1:0]   src_addr;
    logic [IP_W-1:0]   dst_addr;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
    logic [IP_W:0]     seq_p1;    // sequence + 1, no wrap
    logic [IP_W-1:0]   ack_num;
  } cmd_t;

  typedef struct packed {
    rpt_kind_e         kind;
    logic [IP_W-1:0]   attacker_ip;
    logic [CNT_W-1:0]  count;
    logic              attacked;
  } rpt_t;

endpackage

// ----- rtl/core/sfd_fifo.sv -----
// sfd_fifo: small register-based command queue between parser and engine.
// Generic width and depth; no package dependency.
module sfd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o,
  output logic             full_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == FullCnt);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/sfd_parser.sv -----
// sfd_parser: front end; tracks byte position, captures header fields and
// emits a command per qualifying frame end or window end. Uses sfd_pkg.
module sfd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  sfd_pkg::op_e  opcode_i,
  input  logic [7:0]    frame_byte_i,
  input  logic          last_byte_i,
  output logic          push_o,
  output sfd_pkg::cmd_t cmd_o
);
  import sfd_pkg::*;

  localparam logic [POS_W-1:0] PosMax  = POS_W'(FRAME_MIN);
  localparam logic [POS_W-1:0] PosLast = POS_W'(FRAME_MIN - 1);
  localparam logic [POS_W-1:0] T0      = POS_W'(TCP_HDR_POS);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       ether_q, ether_d;
  logic [7:0]        proto_q, proto_d;
  logic [IP_W-1:0]   src_q, src_d, dst_q, dst_d, seq_q, seq_d, ack_q, ack_d;
  logic [PORT_W-1:0] sport_q, sport_d, dport_q, dport_d;
  logic [7:0]        flags_q, flags_d;
  logic              byte_in;

  assign byte_in = accept_i && (opcode_i == OP_BYTE);

  always_comb begin
    pos_d   = pos_q;
    ether_d = ether_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    sport_d = sport_q;
    dport_d = dport_q;
    seq_d   = seq_q;
    ack_d   = ack_q;
    flags_d = flags_q;
    if (byte_in) begin
      if (pos_q == POS_W'(12) || pos_q == POS_W'(13)) begin
        ether_d = {ether_q[7:0], frame_byte_i};
      end else if (pos_q == POS_W'(23)) begin
        proto_d = frame_byte_i;
      end else if (pos_q >= POS_W'(26) && pos_q <= POS_W'(29)) begin
        src_d = {src_q[23:0], frame_byte_i};
      end else if (pos_q >= POS_W'(30) && pos_q <= POS_W'(33)) begin
        dst_d = {dst_q[23:0], frame_byte_i};
      end else if (pos_q == T0 || pos_q == T0 + POS_W'(1)) begin
        sport_d = {sport_q[7:0], frame_byte_i};
      end else if (pos_q == T0 + POS_W'(2) || pos_q == T0 + POS_W'(3)) begin
        dport_d = {dport_q[7:0], frame_byte_i};
      end else if (pos_q >= T0 + POS_W'(4) && pos_q <= T0 + POS_W'(7)) begin
        seq_d = {seq_q[23:0], frame_byte_i};
      end else if (pos_q >= T0 + POS_W'(8) && pos_q <= T0 + POS_W'(11)) begin
        ack_d = {ack_q[23:0], frame_byte_i};
      end else if (pos_q == T0 + POS_W'(13)) begin
        flags_d = frame_byte_i;
      end
      if (last_byte_i) begin
        pos_d = '0;
      end else if (pos_q < PosMax) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // Push at window end, or at the last byte of a frame of FRAME_MIN bytes or more
  always_comb begin
    push_o = accept_i &&
             ((opcode_i == OP_WINDOW_END) || (last_byte_i && pos_q >= PosLast));
    cmd_o.kind     = opcode_i;
    cmd_o.ipv4_tcp = (ether_d == ETH_TYPE_IPV4) && (proto_d == IP_PROTO_TCP);
    cmd_o.syn      = flags_d[FLAG_SYN_BIT];
    cmd_o.ack      = flags_d[FLAG_ACK_BIT];
    cmd_o.src_addr = src_d;
    cmd_o.dst_addr = dst_d;
    cmd_o.src_port = sport_d;
    cmd_o.dst_port = dport_d;
    cmd_o.seq_p1   = {1'b0, seq_d} + (IP_W+1)'(1);
    cmd_o.ack_num  = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ether_q <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      sport_q <= '0;
      dport_q <= '0;
      seq_q   <= '0;
      ack_q   <= '0;
      flags_q <= '0;
    end else begin
      pos_q   <= pos_d;
      ether_q <= ether_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      sport_q <= sport_d;
      dport_q <= dport_d;
      seq_q   <= seq_d;
      ack_q   <= ack_d;
      flags_q <= flags_d;
    end
  end

endmodule

// ----- rtl/core/sfd_engine.sv -----
// sfd_engine: back end; applies filters, updates the half-open count and
// the stored SYN-ACK sequence, and holds the output register. Uses sfd_pkg.
module sfd_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfd_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  sfd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output sfd_pkg::rpt_t out_o
);
  import sfd_pkg::*;

  localparam logic signed [CNT_W-1:0] CntMax = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CntMin = {1'b1, {(CNT_W-1){1'b0}}};
  localparam logic signed [CNT_W-1:0] CntOne = {{(CNT_W-1){1'b0}}, 1'b1};

  logic signed [CNT_W-1:0] cnt_q, cnt_d, cnt_upd;
  logic [IP_W:0]           sa_p1_q, sa_p1_d, sa_eff;
  logic                    out_valid_q, out_valid_d;
  rpt_t                    out_q, out_d;

  logic from_host, touch, act, upd_sa, port_ok, go, dec, inc, report, hit;
  logic signed [CNT_W:0] thr_s;

  assign pop_o       = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign thr_s       = $signed({2'b00, cfg_i.threshold});

  always_comb begin
    from_host = (cmd_i.src_addr == cfg_i.listen_ip);
    touch     = from_host || (cmd_i.dst_addr == cfg_i.listen_ip);
    act       = cmd_i.ipv4_tcp && touch;
    upd_sa    = act && cmd_i.syn && cmd_i.ack;
    sa_eff    = upd_sa ? cmd_i.seq_p1 : sa_p1_q;
    // negative filter other than "all" matches nothing
    port_ok   = (cfg_i.listen_port == LPORT_ALL) ||
                (!cfg_i.listen_port[LPORT_W-1] &&
                 ((cmd_i.src_port == cfg_i.listen_port[PORT_W-1:0]) ||
                  (cmd_i.dst_port == cfg_i.listen_port[PORT_W-1:0])));
    go        = act && port_ok;
    dec       = go && cmd_i.ack && !from_host && ({1'b0, cmd_i.ack_num} == sa_eff) &&
                (cnt_q != CntMin);
    inc       = go && cmd_i.syn && !cmd_i.ack && !from_host && (cnt_q != CntMax);
    cnt_upd   = dec ? cnt_q - CntOne : (inc ? cnt_q + CntOne : cnt_q);
    report    = go && ($signed({cnt_upd[CNT_W-1], cnt_upd}) >= thr_s);
    hit       = ($signed({cnt_q[CNT_W-1], cnt_q}) > thr_s);
  end

  always_comb begin
    cnt_d       = cnt_q;
    sa_p1_d     = sa_p1_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      unique case (cmd_i.kind)
        OP_WINDOW_END: begin
          out_d.kind        = RPT_SUMMARY;
          out_d.attacker_ip = '0;
          out_d.count       = cnt_q;
          out_d.attacked    = hit;
          out_valid_d       = 1'b1;
          if (hit) begin
            cnt_d = '0;
          end
        end
        OP_BYTE: begin
          sa_p1_d = sa_eff;
          cnt_d   = cnt_upd;
          if (report) begin
            out_d.kind        = RPT_ATTACKER;
            out_d.attacker_ip = from_host ? cmd_i.dst_addr : cmd_i.src_addr;
            out_d.count       = cnt_upd;
            out_d.attacked    = 1'b0;
            out_valid_d       = 1'b1;
          end
        end
        default: begin
          out_valid_d = out_valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sa_p1_q     <= (IP_W+1)'(1);   // stored sequence 0, plus one
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      sa_p1_q     <= sa_p1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ----- rtl/core/syn_flood_detector.sv -----
// syn_flood_detector: top level; config registers, parser, command queue,
// counting engine. Uses sfd_pkg, sfd_parser, sfd_fifo, sfd_engine.
// Throughput: one item per cycle on the input stream while the queue has room.
// Path: an accepted item's command, if any, is written into the queue, then into
//   the engine output register when popped; popping waits while the output is held.
// Reset (rst_ni low, async): count, captures and stored sequence clear,
//   listen_port reads as -1 (all ports), other config registers zero.
module syn_flood_detector #(
  parameter int unsigned FifoDepth = sfd_pkg::CMD_FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] frame_byte
  input  logic                        s_axis_tlast,   // last_byte
  input  logic [0:0]                  s_axis_tuser,   // [0] opcode
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata,   // [31:0] attacker_ip,
                                                      // [47:32] half_open_count,
                                                      // [48] attacked, rest zero
  output logic [0:0]                  m_axis_tuser,   // [0] report_kind
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfd_pkg::CFG_W-1:0]   cfg_data_i
);
  import sfd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic in_accept, push, fifo_full, fifo_valid, pop, out_valid;
  cmd_t cmd_in, cmd_head;
  rpt_t rpt;
  logic [$bits(cmd_t)-1:0] head_bits;

  // Config: the user must write it only while idle (not enforced); read directly by the engine
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LISTEN_IP:   cfg_d.listen_ip   = cfg_data_i[IP_W-1:0];
        CFG_LISTEN_PORT: cfg_d.listen_port = cfg_data_i[LPORT_W-1:0];
        CFG_THRESHOLD:   cfg_d.threshold   = cfg_data_i[THR_W-1:0];
        CFG_UNUSED:      cfg_d = cfg_q;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.listen_ip   <= '0;
      cfg_q.listen_port <= LPORT_ALL;
      cfg_q.threshold   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input is held off only when the queue is full
  assign s_axis_tready = !fifo_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Front: byte position tracking and header capture
  sfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .opcode_i     (op_e'(s_axis_tuser[0])),
    .frame_byte_i (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  // Queue of frame-end and window-end commands
  sfd_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .pop_i   (pop),
    .rdata_o (head_bits),
    .valid_o (fifo_valid),
    .full_o  (fifo_full)
  );

  assign cmd_head = cmd_t'(head_bits);

  // Back: count update and output register
  sfd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (out_valid),
    .out_o       (rpt)
  );

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tuser[0] = rpt.kind;
  assign m_axis_tdata    = {7'b0, rpt.attacked, rpt.count, rpt.attacker_ip};

  // A window-end item always lands in the queue
  a_window_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (s_axis_tuser[0] == OP_WINDOW_END) |=> fifo_valid)
    else $error("window-end item not queued");

  // Popping a window-end command always yields a summary
  a_window_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (cmd_head.kind == OP_WINDOW_END) |=>
      m_axis_tvalid && (m_axis_tuser[0] == RPT_SUMMARY))
    else $error("window end without summary");

  // Attacker reports never carry the attacked flag
  a_attacker_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == RPT_ATTACKER) |-> !m_axis_tdata[48])
    else $error("attacker report with attacked set");

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for syn_flood_detector; byte stream in, report stream out.
// Depends on sfd_pkg and the syn_flood_detector RTL. A built-in tracker predicts
// every report, and directed then random frame traffic runs with random idling.
module testbench;
  import sfd_pkg::*;

  localparam logic [7:0] FL_SYN = 8'h01 << FLAG_SYN_BIT;
  localparam logic [7:0] FL_ACK = 8'h01 << FLAG_ACK_BIT;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 80;
  localparam int SETTLE_CYCLES = 16;   // queue depth plus output stages, with margin
  localparam int MAX_PRINTED  = 40;

  // one TCP/IPv4 frame as the generator sees it, before serialization
  typedef struct {
    logic [15:0] eth;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [31:0] ackn;
    logic [7:0]  flags;
    int          len;
  } tcp_frame_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // [7:0] frame_byte
  logic                 s_axis_tlast  = 1'b0; // last_byte
  logic [0:0]           s_axis_tuser  = '0;   // [0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;         // [31:0] attacker_ip, [47:32] count,
                                              // [48] attacked
  logic [0:0]           m_axis_tuser;         // [0] report_kind
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  syn_flood_detector dut (.*);

  // ---------------------------------------------------------------------------
  // Detector tracker: mirror of config and capture state, updated per accepted item
  // ---------------------------------------------------------------------------
  logic [31:0] cfg_ip    = '0;
  logic [16:0] cfg_lport = LPORT_ALL;
  logic [14:0] cfg_thr   = '0;

  int unsigned pos_q    = 0;
  logic [15:0] eth_q    = '0;
  logic [7:0]  proto_q  = '0;
  logic [31:0] src_q    = '0;
  logic [31:0] dst_q    = '0;
  logic [15:0] sport_q  = '0;
  logic [15:0] dport_q  = '0;
  logic [31:0] seq_q    = '0;
  logic [31:0] ackn_q   = '0;
  logic [7:0]  flags_q  = '0;
  logic [31:0] synack_q = '0;
  int          count_q  = 0;

  rpt_t pending_reports[$];

  int error_count   = 0;
  int items_sent    = 0;
  int frames_sent   = 0;
  int attack_seen   = 0;
  int summary_seen  = 0;
  int settings_used = 1;   // reset values count as the first setting

  bit gaps_on          = 1'b0;
  bit stalls_on        = 1'b0;
  bit scatter_windows  = 1'b0;
  int stall_left       = 0;
  int hold_left        = 0;

  logic [31:0] peer_pool [4];

  // Returns 1 and the expected report when the item produces one.
  function automatic bit compute_report(input op_e op, input logic [7:0] b,
                                        input logic is_last, output rpt_t r);
    int unsigned p;
    int          lp;
    bit          syn, ackf, from_host, emit;
    r    = '0;
    emit = 1'b0;
    if (op == OP_WINDOW_END) begin
      // window end: frame under assembly untouched, count cleared on attack
      r.kind     = RPT_SUMMARY;
      r.count    = count_q[15:0];
      r.attacked = count_q > int'(cfg_thr);
      if (r.attacked) count_q = 0;
      return 1'b1;
    end
    p = pos_q;
    if (p == 12 || p == 13) eth_q = {eth_q[7:0], b};
    else if (p == 23) proto_q = b;
    else if (p >= 26 && p <= 29) src_q = {src_q[23:0], b};
    else if (p >= 30 && p <= 33) dst_q = {dst_q[23:0], b};
    else if (p == TCP_HDR_POS || p == TCP_HDR_POS + 1) sport_q = {sport_q[7:0], b};
    else if (p == TCP_HDR_POS + 2 || p == TCP_HDR_POS + 3) dport_q = {dport_q[7:0], b};
    else if (p >= TCP_HDR_POS + 4 && p <= TCP_HDR_POS + 7) seq_q = {seq_q[23:0], b};
    else if (p >= TCP_HDR_POS + 8 && p <= TCP_HDR_POS + 11) ackn_q = {ackn_q[23:0], b};
    else if (p == TCP_HDR_POS + 13) flags_q = b;

    if (is_last && p + 1 >= FRAME_MIN && eth_q == ETH_TYPE_IPV4 && proto_q == IP_PROTO_TCP
        && (src_q == cfg_ip || dst_q == cfg_ip)) begin
      syn       = flags_q[FLAG_SYN_BIT];
      ackf      = flags_q[FLAG_ACK_BIT];
      from_host = (src_q == cfg_ip);
      // SYN-ACK sequence is kept even when the port filter drops the frame
      if (syn && ackf) synack_q = seq_q;
      lp = cfg_lport[16] ? int'(cfg_lport[15:0]) - 65536 : int'(cfg_lport);
      if (lp == -1 || int'(sport_q) == lp || int'(dport_q) == lp) begin
        // ack must equal stored sequence + 1 at 33 bits, so all-ones never matches
        if (ackf && !from_host && {1'b0, ackn_q} == {1'b0, synack_q} + 33'd1
            && count_q > -32768) count_q--;
        if (syn && !ackf && !from_host && count_q < 32767) count_q++;
        if (count_q >= int'(cfg_thr)) begin
          r.kind        = RPT_ATTACKER;
          r.attacker_ip = from_host ? dst_q : src_q;
          r.count       = count_q[15:0];
          emit          = 1'b1;
        end
      end
    end
    if (is_last) pos_q = 0;
    else if (p < FRAME_MIN) pos_q = p + 1;
    return emit;
  endfunction

  task automatic log_error(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR t=%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout: output stream stopped before all reports arrived");
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready moves at the falling edge; long hold first, then per-item stall
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker: compares every accepted report with the oldest expectation
  always @(posedge clk_i) begin : result_check
    rpt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser[0] == RPT_SUMMARY) summary_seen++;
      else attack_seen++;
      if (pending_reports.size() == 0) begin
        log_error($sformatf("report with nothing expected: kind %0d data %h",
                            m_axis_tuser[0], m_axis_tdata));
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tuser[0] !== want.kind)
          log_error($sformatf("report_kind %0d, expected %0d", m_axis_tuser[0], want.kind));
        if (m_axis_tdata[31:0] !== want.attacker_ip)
          log_error($sformatf("attacker_ip %h, expected %h",
                              m_axis_tdata[31:0], want.attacker_ip));
        if (m_axis_tdata[47:32] !== want.count)
          log_error($sformatf("half_open_count %0d, expected %0d",
                              $signed(m_axis_tdata[47:32]), $signed(want.count)));
        if (m_axis_tdata[48] !== want.attacked)
          log_error($sformatf("attacked %0d, expected %0d", m_axis_tdata[48], want.attacked));
      end
      stall_left = stalls_on ? $urandom_range(0, 10) : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // One item; returns at the rising edge that accepted it.
  task automatic send_item(input op_e op, input logic [7:0] b, input logic is_last);
    int   gap;
    rpt_t r;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    s_axis_tuser  <= op;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    if (compute_report(op, b, is_last, r)) pending_reports.push_back(r);
    items_sent++;
  endtask

  // Serialize a frame; a window end goes in before byte cut (none if negative),
  // or at random spots when scattering is on.
  task automatic send_frame(input tcp_frame_t f, input int cut);
    logic [7:0] b;
    int         t;
    t = TCP_HDR_POS;
    for (int i = 0; i < f.len; i++) begin
      if (i == cut) send_item(OP_WINDOW_END, 8'($urandom), 1'b1);
      else if (scatter_windows && i > 0 && $urandom_range(0, 199) == 0)
        send_item(OP_WINDOW_END, 8'($urandom), 1'($urandom));
      b = 8'($urandom);
      if (i == 12) b = f.eth[15:8];
      else if (i == 13) b = f.eth[7:0];
      else if (i == 23) b = f.proto;
      else if (i >= 26 && i <= 29) b = f.src[8*(29-i) +: 8];
      else if (i >= 30 && i <= 33) b = f.dst[8*(33-i) +: 8];
      else if (i >= t && i <= t + 1) b = f.sport[8*(t+1-i) +: 8];
      else if (i >= t + 2 && i <= t + 3) b = f.dport[8*(t+3-i) +: 8];
      else if (i >= t + 4 && i <= t + 7) b = f.seq[8*(t+7-i) +: 8];
      else if (i >= t + 8 && i <= t + 11) b = f.ackn[8*(t+11-i) +: 8];
      else if (i == t + 13) b = f.flags;
      send_item(OP_BYTE, b, i == f.len - 1);
    end
    frames_sent++;
  endtask

  // Well-formed TCP frame; when a single port is watched, usually aimed at it.
  function automatic tcp_frame_t make_frame(input logic [31:0] src, input logic [31:0] dst,
                                            input logic [7:0] flags);
    tcp_frame_t f;
    f.eth   = ETH_TYPE_IPV4;
    f.proto = IP_PROTO_TCP;
    f.src   = src;
    f.dst   = dst;
    f.sport = 16'($urandom);
    f.dport = 16'($urandom);
    f.seq   = $urandom;
    f.ackn  = $urandom;
    f.flags = flags;
    f.len   = FRAME_MIN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 22) : 0);
    if (!cfg_lport[16] && $urandom_range(0, 7) != 0) begin
      if (src == cfg_ip) f.sport = cfg_lport[15:0];
      else f.dport = cfg_lport[15:0];
    end
    return f;
  endfunction

  // Stop offering, wait for every expected report, then let the pipe empty.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_LISTEN_IP:   cfg_ip    = value;
      CFG_LISTEN_PORT: cfg_lport = value[16:0];
      CFG_THRESHOLD:   cfg_thr   = value[14:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] ip, input logic [16:0] port,
                            input logic [14:0] thr);
    write_reg(CFG_LISTEN_IP, ip);
    write_reg(CFG_LISTEN_PORT, {15'd0, port});
    write_reg(CFG_THRESHOLD, {17'd0, thr});
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  localparam logic [31:0] HOST   = 32'hC0A8_0001;
  localparam logic [31:0] PEER_A = 32'h0A00_0005;
  localparam logic [31:0] PEER_B = 32'hCB00_7109;

  // Reset values: host 0.0.0.0, all ports, threshold 0
  task automatic test_reset_defaults();
    send_frame(make_frame(PEER_A, 32'd0, FL_SYN), -1);
    send_item(OP_WINDOW_END, 8'h00, 1'b0);
  endtask

  task automatic test_handshake();
    tcp_frame_t f;
    set_config(HOST, LPORT_ALL, 15'd0);
    send_frame(make_frame(PEER_A, HOST, FL_SYN), -1);            // count up
    f = make_frame(HOST, PEER_A, FL_SYN | FL_ACK);               // offer stored
    f.seq = 32'h1234_5678;
    send_frame(f, -1);
    f = make_frame(PEER_A, HOST, FL_ACK);                        // completes: count down
    f.ackn = 32'h1234_5679;
    send_frame(f, -1);
    send_frame(make_frame(PEER_B, HOST, FL_SYN | FL_ACK), -1);   // SYN+ACK adds nothing
    f = make_frame(HOST, PEER_B, FL_SYN | FL_ACK);               // all-ones sequence
    f.seq = '1;
    send_frame(f, -1);
    f = make_frame(PEER_B, HOST, FL_ACK);                        // wrapped ack: no match
    f.ackn = '0;
    send_frame(f, -1);
    send_frame(make_frame(HOST, PEER_A, FL_SYN), -1);            // SYN from host itself
    send_item(OP_WINDOW_END, 8'hFF, 1'b1);
  endtask

  task automatic test_frame_lengths();
    tcp_frame_t f;
    f = make_frame(PEER_A, HOST, FL_SYN);
    f.len = FRAME_MIN - 1;                                       // one short: ignored
    send_frame(f, -1);
    f.len = FRAME_MIN;
    send_frame(f, -1);
    f.len = 100;                                                 // position saturates
    send_frame(f, -1);
    f.len = 1;
    send_frame(f, -1);
    f = make_frame(PEER_B, HOST, FL_SYN);                        // window end mid-frame
    send_frame(f, 20);
    send_item(OP_WINDOW_END, 8'h00, 1'b0);
  endtask

  task automatic test_port_filter();
    tcp_frame_t f;
    set_config(HOST, 17'd80, 15'd0);
    f = make_frame(PEER_A, HOST, FL_SYN);
    f.sport = 16'd1000;
    f.dport = 16'd80;
    send_frame(f, -1);                                           // watched port
    f.dport = 16'd81;
    send_frame(f, -1);                                           // filtered
    f = make_frame(HOST, PEER_A, FL_SYN | FL_ACK);               // filtered, seq still kept
    f.sport = 16'd81;
    f.dport = 16'd1000;
    f.seq   = 32'hCAFE_0000;
    send_frame(f, -1);
    f = make_frame(PEER_A, HOST, FL_ACK);
    f.sport = 16'd1000;
    f.dport = 16'd80;
    f.ackn  = 32'hCAFE_0001;
    send_frame(f, -1);
    write_reg(CFG_LISTEN_PORT, 32'h0001_0000);                   // negative: matches nothing
    f = make_frame(PEER_A, HOST, FL_SYN);
    f.sport = 16'd0;
    f.dport = 16'hFFFF;
    send_frame(f, -1);
    write_reg(CFG_LISTEN_PORT, 32'd0);                           // source port match
    send_frame(f, -1);
    write_reg(CFG_LISTEN_PORT, 32'd65535);                       // destination port match
    send_frame(f, -1);
    write_reg(CFG_LISTEN_PORT, {15'd0, LPORT_ALL});
    f = make_frame(PEER_A, HOST, FL_SYN);
    f.eth = 16'h86DD;                                            // not IPv4
    send_frame(f, -1);
    f = make_frame(PEER_A, HOST, FL_SYN);
    f.proto = 8'd17;                                             // not TCP
    send_frame(f, -1);
    send_frame(make_frame(PEER_A, PEER_B, FL_SYN), -1);          // host not involved
    write_reg(CFG_LISTEN_IP, 32'hFFFF_FFFF);
    send_frame(make_frame(PEER_A, 32'hFFFF_FFFF, FL_SYN), -1);
    send_item(OP_WINDOW_END, 8'h00, 1'b0);
    settings_used += 5;
  endtask

  task automatic test_threshold();
    tcp_frame_t f;
    set_config(HOST, LPORT_ALL, 15'h7FFF);
    repeat (2) send_frame(make_frame(PEER_A, HOST, FL_SYN), -1); // no reports at max
    send_item(OP_WINDOW_END, 8'h00, 1'b0);
    write_reg(CFG_THRESHOLD, 32'd2);
    send_frame(make_frame(PEER_B, HOST, FL_SYN), -1);            // above threshold
    send_item(OP_WINDOW_END, 8'h00, 1'b0);                       // attack seen, cleared
    repeat (2) send_frame(make_frame(PEER_A, HOST, FL_SYN), -1); // reaches threshold
    send_item(OP_WINDOW_END, 8'h00, 1'b0);                       // equal: no attack
    write_reg(CFG_THRESHOLD, 32'd0);
    f = make_frame(HOST, PEER_B, FL_SYN | FL_ACK);
    f.seq = 32'h0000_FFFF;
    send_frame(f, -1);
    f = make_frame(HOST, PEER_B, FL_ACK);                        // ack from host: ignored
    f.ackn = 32'h0001_0000;
    send_frame(f, -1);
    f = make_frame(PEER_B, HOST, FL_ACK);                        // drive count negative
    f.ackn = 32'h0001_0000;
    repeat (3) send_frame(f, -1);
    send_item(OP_WINDOW_END, 8'h00, 1'b0);
    settings_used += 2;
  endtask

  // Receiver holds off while the sender keeps going, so the block stalls its input.
  task automatic test_backpressure();
    set_config(HOST, LPORT_ALL, 15'd0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    hold_left = 300;
    repeat (4) send_frame(make_frame(PEER_A, HOST, FL_SYN), -1);
    repeat (30) send_item(OP_WINDOW_END, 8'($urandom), 1'($urandom));
    wait_idle();
  endtask

  // Phases of random traffic, each under its own register setting.
  task automatic test_random_traffic();
    tcp_frame_t  f;
    logic [31:0] peer, offer;
    logic [16:0] port;
    logic [14:0] thr;
    int          pick, phase, phase_start;
    phase           = 0;
    offer           = $urandom;
    scatter_windows = 1'b1;
    foreach (peer_pool[k]) peer_pool[k] = $urandom;
    while (phase < RANDOM_PHASES) begin
      case (phase % 5)
        0: port = LPORT_ALL;
        1: port = {1'b0, 16'($urandom)};
        2: port = 17'd0;
        3: port = 17'd65535;
        default: port = {1'b1, 16'($urandom_range(0, 65534))};
      endcase
      if (phase == 3) thr = 15'h7FFF;
      else if (phase % 2 == 0) thr = 15'd0;
      else thr = 15'($urandom_range(1, 4));
      set_config(phase == 1 ? 32'hFFFF_FFFF : (phase == 2 ? 32'd0 : $urandom), port, thr);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
        if ($urandom_range(0, 9) == 0) stalls_on = !stalls_on;
        peer = ($urandom_range(0, 3) == 0) ? $urandom : peer_pool[$urandom_range(0, 3)];
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          f = make_frame(peer, cfg_ip, FL_SYN);
        end else if (pick < 45) begin
          f = make_frame(cfg_ip, peer, FL_SYN | FL_ACK);
          if ($urandom_range(0, 7) == 0) f.seq = '1;
          offer = f.seq;
        end else if (pick < 62) begin
          f = make_frame(peer, cfg_ip, FL_ACK);
          f.ackn = offer + 32'd1;
        end else if (pick < 68) begin
          f = make_frame(peer, cfg_ip, FL_SYN | FL_ACK);
        end else if (pick < 78) begin
          f = ($urandom_range(0, 1) == 0) ? make_frame(peer, cfg_ip, 8'($urandom))
                                          : make_frame(cfg_ip, peer, 8'($urandom));
        end else if (pick < 86) begin
          // broken header: wrong ethertype, wrong protocol or foreign addresses
          f = make_frame(peer, cfg_ip, FL_SYN);
          case ($urandom_range(0, 2))
            0: f.eth = 16'($urandom);
            1: f.proto = 8'($urandom);
            default: f.dst = $urandom;
          endcase
        end else if (pick < 93) begin
          f = make_frame(peer, cfg_ip, FL_SYN);
          f.len = $urandom_range(1, FRAME_MIN - 1);
        end else begin
          f = make_frame($urandom, $urandom, 8'($urandom));
          f.eth   = 16'($urandom);
          f.proto = 8'($urandom);
          f.len   = $urandom_range(1, 70);
        end
        send_frame(f, -1);
        if ($urandom_range(0, 11) == 0) send_item(OP_WINDOW_END, 8'($urandom), 1'($urandom));
      end
      phase++;
    end
    scatter_windows = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_handshake();
    test_frame_lengths();
    test_port_filter();
    test_threshold();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_backpressure();
    test_random_traffic();
    wait_idle();

    $display("run: %0d items in %0d frames under %0d register settings",
             items_sent, frames_sent, settings_used);
    $display("run: %0d attacker reports and %0d window summaries checked",
             attack_seen, summary_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
